/* rtl/core/uer_pkg.sv */
// shared types and constants for the ultrasonic echo ranger
`timescale 1ns / 1ps

package uer_pkg;

    localparam int SAMPLES     = 4;
    localparam int US_PER_CM   = 58;
    localparam int TICK_W      = 16;
    localparam int REM_W       = 6;
    localparam int CM_W        = 11;
    localparam int SUM_W       = 15;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 1;

    // reciprocal for the mean: exact for every 15 bit sum and SAMPLES up to 16
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES);

    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
    localparam logic [REM_W-1:0]  REM_LAST      = REM_W'(US_PER_CM - 1);
    localparam logic [TICK_W-1:0] TRIG_RESET    = 16'd11;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } t_phase;

    typedef struct packed {
        logic echo_level;
        logic start_req;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0] trigger_ticks;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic            trigger_level;
        logic            busy_res;
        logic            range_valid;
        logic [CM_W-1:0] range_cm;
        logic            timed_out;
    } t_result;

endpackage

/* rtl/core/uer_cfg_regs.sv */
// configuration registers for trigger length and echo timeout
`timescale 1ns / 1ps

module uer_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uer_pkg::TICK_W-1:0]      i_cfg_data,
    output logic                            o_cfg_ready,
    output uer_pkg::t_cfg                   o_cfg
);

    uer_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= uer_pkg::TRIG_RESET;
            r_cfg.timeout_ticks <= uer_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uer_pkg::CFG_TRIGGER_TICKS: r_cfg.trigger_ticks <= i_cfg_data;
                uer_pkg::CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/uer_in_reg.sv */
// input register holding one accepted tick item
`timescale 1ns / 1ps

module uer_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  uer_pkg::t_item i_item,
    output logic           o_in_ready,
    input  logic           i_advance,
    output logic           o_valid,
    output uer_pkg::t_item o_item
);

    logic           r_valid;
    uer_pkg::t_item r_item;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/uer_ranger.sv */
// ranging state machine: trigger, echo width, running sum and mean
`timescale 1ns / 1ps

module uer_ranger (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  uer_pkg::t_item   i_item,
    input  uer_pkg::t_cfg    i_cfg,
    output uer_pkg::t_result o_result
);

    uer_pkg::t_phase                r_phase, n_phase;
    logic [uer_pkg::TICK_W-1:0]     r_tick, n_tick;
    // tick count kept also as quotient and remainder by 58
    logic [uer_pkg::CM_W-1:0]       r_cm_q, n_cm_q;
    logic [uer_pkg::REM_W-1:0]      r_cm_r, n_cm_r;
    logic                           r_prev_echo;
    logic [uer_pkg::SUM_W-1:0]      r_sum, n_sum;
    logic [uer_pkg::IDX_W-1:0]      r_index, n_index;
    logic [uer_pkg::CM_W-1:0]       r_last, n_last;

    logic [uer_pkg::SUM_W-1:0]      w_sum_add;
    logic [uer_pkg::IDX_W-1:0]      w_index_add;
    logic [uer_pkg::PROD_W-1:0]     w_prod;
    logic [uer_pkg::TICK_W-1:0]     w_tick_inc;
    logic [uer_pkg::CM_W-1:0]       w_q_inc;
    logic [uer_pkg::REM_W-1:0]      w_r_inc;
    logic                           w_rising;
    logic                           w_trig, w_valid, w_tout;

    assign w_rising    = i_item.echo_level && !r_prev_echo;
    assign w_sum_add   = r_sum + uer_pkg::SUM_W'(r_cm_q);
    assign w_index_add = r_index + uer_pkg::IDX_W'(1);
    assign w_prod      = uer_pkg::PROD_W'(w_sum_add) * uer_pkg::PROD_W'(uer_pkg::RECIP);

    // saturating increment of the tick count and its quotient and remainder
    always_comb begin
        w_tick_inc = r_tick;
        w_q_inc    = r_cm_q;
        w_r_inc    = r_cm_r;
        if (r_tick != uer_pkg::TICK_MAX) begin
            w_tick_inc = r_tick + uer_pkg::TICK_W'(1);
            if (r_cm_r == uer_pkg::REM_LAST) begin
                w_r_inc = '0;
                w_q_inc = r_cm_q + uer_pkg::CM_W'(1);
            end else begin
                w_r_inc = r_cm_r + uer_pkg::REM_W'(1);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_cm_q  = r_cm_q;
        n_cm_r  = r_cm_r;
        n_sum   = r_sum;
        n_index = r_index;
        n_last  = r_last;
        w_trig  = 1'b0;
        w_valid = 1'b0;
        w_tout  = 1'b0;
        case (r_phase)
            uer_pkg::PH_IDLE, uer_pkg::PH_WAIT: begin
                if (i_item.start_req) begin
                    w_trig  = 1'b1;
                    n_tick  = uer_pkg::TICK_W'(1);
                    n_cm_q  = '0;
                    n_cm_r  = uer_pkg::REM_W'(1);
                    n_phase = (i_cfg.trigger_ticks <= uer_pkg::TICK_W'(1)) ?
                              uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
                end else if (r_phase == uer_pkg::PH_WAIT && w_rising) begin
                    n_tick = uer_pkg::TICK_W'(1);
                    n_cm_q = '0;
                    n_cm_r = uer_pkg::REM_W'(1);
                    if (i_cfg.timeout_ticks <= uer_pkg::TICK_W'(1)) begin
                        w_tout  = 1'b1;
                        n_phase = uer_pkg::PH_IDLE;
                    end else begin
                        n_phase = uer_pkg::PH_MEAS;
                    end
                end
            end
            uer_pkg::PH_TRIG: begin
                w_trig = 1'b1;
                n_tick = w_tick_inc;
                n_cm_q = w_q_inc;
                n_cm_r = w_r_inc;
                if (w_tick_inc >= i_cfg.trigger_ticks) begin
                    n_phase = uer_pkg::PH_WAIT;
                end
            end
            uer_pkg::PH_MEAS: begin
                if (!i_item.echo_level) begin
                    n_phase = uer_pkg::PH_IDLE;
                    if (w_index_add >= uer_pkg::IDX_W'(uer_pkg::SAMPLES)) begin
                        n_last  = w_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::CM_W];
                        w_valid = 1'b1;
                        n_sum   = '0;
                        n_index = '0;
                    end else begin
                        n_sum   = w_sum_add;
                        n_index = w_index_add;
                    end
                end else begin
                    n_tick = w_tick_inc;
                    n_cm_q = w_q_inc;
                    n_cm_r = w_r_inc;
                    if (w_tick_inc >= i_cfg.timeout_ticks) begin
                        w_tout  = 1'b1;
                        n_phase = uer_pkg::PH_IDLE;
                    end
                end
            end
            default: n_phase = uer_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uer_pkg::PH_IDLE;
            r_tick      <= '0;
            r_cm_q      <= '0;
            r_cm_r      <= '0;
            r_prev_echo <= 1'b0;
            r_sum       <= '0;
            r_index     <= '0;
            r_last      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_cm_q      <= n_cm_q;
            r_cm_r      <= n_cm_r;
            r_prev_echo <= i_item.echo_level;
            r_sum       <= n_sum;
            r_index     <= n_index;
            r_last      <= n_last;
        end
    end

    always_comb begin
        o_result.trigger_level = w_trig;
        o_result.busy_res      = (n_phase == uer_pkg::PH_TRIG) ||
                                 (n_phase == uer_pkg::PH_MEAS);
        o_result.range_valid   = w_valid;
        o_result.range_cm      = n_last;
        o_result.timed_out     = w_tout;
    end

endmodule

/* rtl/core/uer_out_reg.sv */
// result register toward the consumer
`timescale 1ns / 1ps

module uer_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  uer_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output uer_pkg::t_result o_result
);

    logic             r_valid;
    uer_pkg::t_result r_result;
    logic             w_free;

    assign w_free      = !r_valid || i_out_ready;
    assign o_advance   = w_free && i_valid;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/ultrasonic_echo_ranger_unit.sv */
// Ultrasonic echo ranger: one item per microsecond tick (echo level, start request) gives one
// result item (trigger drive, busy, averaged range, timeout). Items flow through an input register,
// a single pass of ranging logic and a result register, so one item is taken every cycle while the
// consumer does not stall the result register, and each result is held in the result register once
// its item has passed the input register and the ranging logic; the rate is set by the phase and
// counter update in the ranging logic. Echo width is divided by 58 with a remainder counter kept
// beside the tick count, and the mean over SAMPLES pulses is a constant reciprocal multiply.
// Configuration writes are taken at once and should be done while no item is in flight.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_echo_level,
    input  logic                            i_start_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_trigger_level,
    output logic                            o_busy_res,
    output logic                            o_range_valid,
    output logic [uer_pkg::CM_W-1:0]        o_range_cm,
    output logic                            o_timed_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uer_pkg::TICK_W-1:0]      i_cfg_data
);

    uer_pkg::t_cfg    w_cfg;
    uer_pkg::t_item   w_in_item;
    uer_pkg::t_item   w_item;
    uer_pkg::t_result w_result;
    uer_pkg::t_result w_out;
    logic             w_item_valid;
    logic             w_advance;

    assign w_in_item.echo_level = i_echo_level;
    assign w_in_item.start_req  = i_start_req;

    uer_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    uer_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .o_in_ready (o_in_ready),
        .i_advance  (w_advance),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    uer_ranger u_ranger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    uer_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_item_valid),
        .i_result    (w_result),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_out)
    );

    assign o_trigger_level = w_out.trigger_level;
    assign o_busy_res      = w_out.busy_res;
    assign o_range_valid   = w_out.range_valid;
    assign o_range_cm      = w_out.range_cm;
    assign o_timed_out     = w_out.timed_out;

endmodule

/* tb/tb_ultrasonic_echo_ranger_unit.sv */
// testbench for the ultrasonic echo ranger: tick predictor, scoreboard and random echo traffic
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_unit;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_SHOWN   = 10;

    // tick-by-tick model of the ranger plus the queue of results still owed by the block
    class range_scoreboard;
        uer_pkg::t_phase                ph;
        logic [uer_pkg::TICK_W-1:0]     ticks;
        logic                           prev_echo;
        logic [uer_pkg::SUM_W-1:0]      cm_sum;
        logic [uer_pkg::IDX_W-1:0]      n_pulses;
        logic [uer_pkg::CM_W-1:0]       mean_cm;
        logic [uer_pkg::TICK_W-1:0]     trig_len;
        logic [uer_pkg::TICK_W-1:0]     tout_len;
        uer_pkg::t_result               awaited[$];
        int                             items;
        int                             checked;
        int                             errors;
        int                             ranges;
        int                             timeouts;

        function new();
            ph        = uer_pkg::PH_IDLE;
            ticks     = '0;
            prev_echo = 1'b0;
            cm_sum    = '0;
            n_pulses  = '0;
            mean_cm   = '0;
            trig_len  = uer_pkg::TRIG_RESET;
            tout_len  = uer_pkg::TIMEOUT_RESET;
            items     = 0;
            checked   = 0;
            errors    = 0;
            ranges    = 0;
            timeouts  = 0;
        endfunction

        function void set_reg(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                              logic [uer_pkg::TICK_W-1:0] data);
            if (idx == uer_pkg::CFG_TRIGGER_TICKS)
                trig_len = data;
            else if (idx == uer_pkg::CFG_TIMEOUT_TICKS)
                tout_len = data;
        endfunction

        function void note_item(logic echo, logic start);
            uer_pkg::t_result         r;
            logic                     rising;
            logic [uer_pkg::CM_W-1:0] cm;
            r      = '0;
            rising = echo && !prev_echo;
            case (ph)
                uer_pkg::PH_IDLE, uer_pkg::PH_WAIT: begin
                    if (start) begin
                        r.trigger_level = 1'b1;
                        ticks = 16'd1;
                        ph = (ticks >= trig_len) ? uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
                    end else if (ph == uer_pkg::PH_WAIT && rising) begin
                        ticks = 16'd1;
                        if (ticks >= tout_len) begin
                            r.timed_out = 1'b1;
                            ph = uer_pkg::PH_IDLE;
                        end else begin
                            ph = uer_pkg::PH_MEAS;
                        end
                    end
                end
                uer_pkg::PH_TRIG: begin
                    r.trigger_level = 1'b1;
                    if (ticks != uer_pkg::TICK_MAX)
                        ticks = ticks + 16'd1;
                    if (ticks >= trig_len)
                        ph = uer_pkg::PH_WAIT;
                end
                default: begin
                    if (!echo) begin
                        cm = uer_pkg::CM_W'(ticks / uer_pkg::US_PER_CM);
                        cm_sum = cm_sum + uer_pkg::SUM_W'(cm);
                        n_pulses = n_pulses + 5'd1;
                        if (n_pulses >= uer_pkg::SAMPLES) begin
                            mean_cm = uer_pkg::CM_W'(cm_sum / uer_pkg::SAMPLES);
                            r.range_valid = 1'b1;
                            cm_sum = '0;
                            n_pulses = '0;
                        end
                        ph = uer_pkg::PH_IDLE;
                    end else begin
                        if (ticks != uer_pkg::TICK_MAX)
                            ticks = ticks + 16'd1;
                        if (ticks >= tout_len) begin
                            r.timed_out = 1'b1;
                            ph = uer_pkg::PH_IDLE;
                        end
                    end
                end
            endcase
            prev_echo  = echo;
            r.busy_res = (ph == uer_pkg::PH_TRIG) || (ph == uer_pkg::PH_MEAS);
            r.range_cm = mean_cm;
            if (r.range_valid)
                ranges++;
            if (r.timed_out)
                timeouts++;
            items++;
            awaited.push_back(r);
        endfunction

        function void check_result(uer_pkg::t_result got);
            uer_pkg::t_result want;
            bit               bad;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("result item with nothing awaited: %s%0b %0b %0b %0d %0b",
                             "trig busy valid cm tout = ",
                             got.trigger_level, got.busy_res, got.range_valid,
                             got.range_cm, got.timed_out);
                return;
            end
            want = awaited.pop_front();
            bad  = (got.trigger_level !== want.trigger_level) ||
                   (got.busy_res !== want.busy_res) ||
                   (got.range_valid !== want.range_valid) ||
                   (got.range_cm !== want.range_cm) ||
                   (got.timed_out !== want.timed_out);
            if (bad) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("mismatch on result %0d: exp trig=%0b busy=%0b valid=%0b %s",
                             checked, want.trigger_level, want.busy_res,
                             want.range_valid, "");
                    $display("    exp cm=%0d tout=%0b, got trig=%0b busy=%0b valid=%0b",
                             want.range_cm, want.timed_out, got.trigger_level,
                             got.busy_res, got.range_valid);
                    $display("    got cm=%0d tout=%0b", got.range_cm, got.timed_out);
                end
            end
            checked++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             i_echo_level = 1'b0;
    logic                             i_start_req  = 1'b0;
    logic                             i_out_ready  = 1'b0;
    logic                             i_cfg_valid  = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [uer_pkg::TICK_W-1:0]       i_cfg_data   = '0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    logic                             o_trigger_level;
    logic                             o_busy_res;
    logic                             o_range_valid;
    logic [uer_pkg::CM_W-1:0]         o_range_cm;
    logic                             o_timed_out;
    logic                             o_cfg_ready;

    range_scoreboard sb = new();

    int cycles     = 0;
    int burst_left = 0;
    int ready_left = 0;
    int stall_left = 0;
    int n_settings = 0;
    bit steady     = 1'b0;

    ultrasonic_echo_ranger_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_echo_level    (i_echo_level),
        .i_start_req     (i_start_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_range_valid   (o_range_valid),
        .o_range_cm      (o_range_cm),
        .o_timed_out     (o_timed_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycles <= cycles + 1;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // receiver: ready runs broken by stalls of mixed length
    always @(negedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else if (ready_left > 0) begin
            i_out_ready <= 1'b1;
            ready_left--;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            ready_left = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0:       stall_left = 0;
                1:       stall_left = $urandom_range(1, 2);
                2:       stall_left = $urandom_range(3, 8);
                default: stall_left = $urandom_range(9, 20);
            endcase
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_trigger_level, o_busy_res, o_range_valid, o_range_cm,
                              o_timed_out});
    end

    // one tick item, sent in bursts with random gaps in between
    task automatic send_item(input logic echo, input logic start);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_echo_level <= echo;
        i_start_req  <= start;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(echo, start);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::TICK_W-1:0] data);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [uer_pkg::TICK_W-1:0] trig,
                             input logic [uer_pkg::TICK_W-1:0] tout);
        write_reg(uer_pkg::CFG_TRIGGER_TICKS, trig);
        write_reg(uer_pkg::CFG_TIMEOUT_TICKS, tout);
        n_settings++;
    endtask

    // trigger, optional disturbance while waiting, then an echo pulse of the given width
    task automatic run_echo_cycle(input int width, input bit noisy);
        int span;
        span = (sb.trig_len == 0) ? 1 : int'(sb.trig_len);
        send_item(noisy ? 1'($urandom) : 1'b0, 1'b1);
        for (int i = 1; i < span; i++)
            send_item(noisy ? 1'($urandom) : 1'b0, noisy ? 1'($urandom) : 1'b0);
        if (noisy) begin
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(1, 3)) send_item(1'b1, 1'b0);
                1: begin
                    // restart from waiting
                    send_item(1'b0, 1'b1);
                    for (int i = 1; i < span; i++)
                        send_item(1'b0, 1'($urandom));
                end
                default: ;
            endcase
        end
        repeat (noisy ? $urandom_range(1, 3) : $urandom_range(0, 3)) send_item(1'b0, 1'b0);
        repeat (width) send_item(1'b1, noisy ? 1'($urandom) : 1'b0);
        send_item(1'b0, noisy ? 1'($urandom) : 1'b0);
    endtask

    function automatic int pick_width();
        int t;
        t = int'(sb.tout_len);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(1, 70);
            5, 6, 7:       return uer_pkg::US_PER_CM * $urandom_range(1, 4) +
                                  $urandom_range(0, 2) - 1;
            8:             return $urandom_range(1, 400);
            default:       return (t >= 2 && t <= 700) ? t - 1 + $urandom_range(0, 2)
                                                       : $urandom_range(1, 200);
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        int first;
        first = sb.items;
        while (sb.items - first < budget) begin
            if ($urandom_range(0, 3) != 0)
                run_echo_cycle(pick_width(), $urandom_range(0, 2) == 0);
            else
                repeat ($urandom_range(1, 8)) send_item(1'($urandom), 1'($urandom));
        end
    endtask

    task automatic directed_ticks();
        // echo while idle is ignored
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        // start with echo high, second start inside the trigger is ignored
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b1);
        // echo already high when waiting begins: no edge
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        // start beats a rising edge while waiting
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        // pulse of three ticks, start during measuring ignored
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        // shortest pulse
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        // no echo, a new start retriggers
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        random_traffic(200);

        configure(16'd2, 16'hFFFF);
        directed_ticks();
        random_traffic(200);

        // zero in both registers acts like one
        configure(16'd0, 16'd0);
        random_traffic(150);

        configure(16'd1, 16'hFFFF);
        random_traffic(100);

        // long trigger sent back to back, echo abandoned on its first tick
        configure(16'd40, 16'd1);
        steady = 1'b1;
        run_echo_cycle(2, 1'b0);
        steady = 1'b0;
        repeat (20) send_item(1'($urandom), 1'b0);

        for (int k = 0; k < 4; k++) begin
            configure(16'($urandom_range(1, 20)),
                      (k % 2 == 0) ? 16'($urandom_range(2, 600)) : 16'($urandom));
            random_traffic(250);
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("%0d tick items checked, %0d averaged ranges, %0d abandoned echoes",
                 sb.checked, sb.ranges, sb.timeouts);
        $display("%0d register settings, including zero and full-scale timeout, %0d mismatches",
                 n_settings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
